### sv/gha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Shared field widths, opcodes, status codes and the result record.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned OpW          = 2;
  localparam int unsigned IdxOutW      = 10;
  localparam int unsigned GenOutW      = 16;
  localparam int unsigned MinFreeW     = 11;
  localparam int unsigned OutFifoDepth = 4;

  typedef enum logic [OpW-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_INDEX    = 2'd1,
    ST_UNALLOCATED = 2'd2,
    ST_OVERFLOW    = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdxOutW-1:0] out_index;
    logic [GenOutW-1:0] out_generation;
    logic               alive;
    status_e            status;
  } rsp_t;

endpackage

### sv/gha_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocator request.
// ----------------------------------------------------------------------------
interface gha_req_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::OpW-1:0]     op;
  logic [gha_pkg::IdxOutW-1:0] index;
  logic [gha_pkg::GenOutW-1:0] generation;

  modport source (output valid, output op, output index, output generation, input ready);
  modport sink   (input valid, input op, input index, input generation, output ready);
endinterface

### sv/gha_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
interface gha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::IdxOutW-1:0] out_index;
  logic [gha_pkg::GenOutW-1:0] out_generation;
  logic                        alive;
  logic [1:0]                  status;

  modport source (output valid, output out_index, output out_generation, output alive,
                  output status, input ready);
  modport sink   (input valid, input out_index, input out_generation, input alive,
                  input status, output ready);
endinterface

### sv/gha_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the min_free register.
// ----------------------------------------------------------------------------
interface gha_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gha_pkg::MinFreeW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/generational_handle_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle allocator
// Creates, destroys and checks handles made of an index and a generation.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  - one request per accepted beat: create, destroy or alive query.
//   rsp_o  - exactly one result per request, in request order.
//   cfg_i  - writes min_free; always ready, write only while idle.
// Path: an accepted request passes the input register and the table read
//   stage, then its result is pushed into the queue and offered on rsp_o.
// Throughput: one request per cycle while rsp_o takes results. The generation
//   table and the free-index ring each do one read and one write per cycle,
//   with a write-to-read bypass between back-to-back requests.
// Reset: counters, pointers and min_free clear; the generation table and
//   the free ring are not cleared (entries are written before being read),
//   so the block is ready in the first cycle after reset.
// Stall: results wait in a 4-entry queue. req_i.ready drops once queued
//   plus in-flight results would fill it, so nothing is ever lost.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit #(
  parameter int unsigned MAX_HANDLES = 1024,
  parameter int unsigned GEN_BITS    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gha_req_if.sink    req_i,
  gha_rsp_if.source  rsp_o,
  gha_cfg_if.sink    cfg_i
);
  import gha_pkg::*;

  localparam int unsigned IdxW   = $clog2(MAX_HANDLES);
  localparam int unsigned CntW   = $clog2(MAX_HANDLES + 1);
  localparam int unsigned CmpW   = (CntW > MinFreeW) ? CntW : MinFreeW;
  localparam int unsigned KnW    = (CntW > IdxOutW) ? CntW : IdxOutW;
  localparam int unsigned FCntW  = $clog2(OutFifoDepth + 1);
  localparam int unsigned OccW   = $clog2(OutFifoDepth + 3);

  typedef enum logic [1:0] {
    GS_ZERO,
    GS_STORED,
    GS_BUMP
  } gsel_e;

  // configuration
  logic [MinFreeW-1:0] min_free_q;

  // input register
  logic                s1_valid_q;
  logic [OpW-1:0]      s1_op_q;
  logic [IdxOutW-1:0]  s1_idx_q;
  logic [GenOutW-1:0]  s1_gen_q;

  // free ring and allocation state
  logic [IdxW-1:0]     head_q, head_d;
  logic [IdxW-1:0]     tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     fresh_q, fresh_d;
  logic [IdxW-1:0]     fq_mem [MAX_HANDLES];
  logic [IdxW-1:0]     fq_head_q;
  logic                fq_we;
  logic                fq_pop;
  logic [IdxW-1:0]     fq_wdata;

  // generation table
  logic [GEN_BITS-1:0] gt_mem [MAX_HANDLES];
  logic [GEN_BITS-1:0] gt_rd_q;
  logic [GEN_BITS-1:0] gt_wdata;
  logic                gt_we;

  // table stage
  logic                s2_valid_q;
  logic [IdxW-1:0]     s2_addr_q, s2_addr_d;
  logic [IdxOutW-1:0]  s2_out_idx_q, s2_out_idx_d;
  status_e             s2_status_q, s2_status_d;
  gsel_e               s2_gsel_q, s2_gsel_d;
  logic                s2_wr_q, s2_wr_d;
  logic                s2_chk_q, s2_chk_d;
  logic [GenOutW-1:0]  s2_qgen_q;

  // decision helpers
  logic                known;
  logic                fresh_left;
  logic                use_free;
  logic                ring_full;

  // result queue
  rsp_t                rsp_d;
  rsp_t                fifo_data;
  logic                fifo_valid;
  logic [FCntW-1:0]    fifo_cnt;
  logic [OccW-1:0]     occupancy;
  logic [GEN_BITS-1:0] gen_val;
  logic                req_fire;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_free_q <= '0;
    end else if (cfg_i.valid) begin
      min_free_q <= cfg_i.data;
    end
  end

  // credit: queued results plus those still in the pipe
  assign occupancy   = OccW'(fifo_cnt) + OccW'(s1_valid_q) + OccW'(s2_valid_q);
  assign req_i.ready = (occupancy < OccW'(OutFifoDepth));
  assign req_fire    = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------------
  // Decision stage: free ring and allocation counters update here, in request order
  // ---------------------------------------------------------------------------
  assign known      = KnW'(s1_idx_q) < KnW'(fresh_q);
  assign fresh_left = (fresh_q != CntW'(MAX_HANDLES));
  assign ring_full  = (count_q == CntW'(MAX_HANDLES));
  assign use_free   = (count_q != '0) &&
                      ((CmpW'(count_q) > CmpW'(min_free_q)) || !fresh_left);
  assign fq_wdata   = IdxW'(s1_idx_q);

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    fresh_d      = fresh_q;
    fq_we        = 1'b0;
    fq_pop       = 1'b0;
    s2_addr_d    = IdxW'(s1_idx_q);
    s2_out_idx_d = s1_idx_q;
    s2_status_d  = ST_OK;
    s2_gsel_d    = GS_ZERO;
    s2_wr_d      = 1'b0;
    s2_chk_d     = 1'b0;
    if (s1_valid_q) begin
      unique case (op_e'(s1_op_q))
        OP_CREATE: begin
          if (use_free) begin
            fq_pop       = 1'b1;
            head_d       = (head_q == IdxW'(MAX_HANDLES - 1)) ? '0 : head_q + IdxW'(1);
            count_d      = count_q - CntW'(1);
            s2_addr_d    = fq_head_q;
            s2_out_idx_d = IdxOutW'(fq_head_q);
            s2_gsel_d    = GS_STORED;
          end else if (fresh_left) begin
            fresh_d      = fresh_q + CntW'(1);
            s2_addr_d    = IdxW'(fresh_q);
            s2_out_idx_d = IdxOutW'(fresh_q);
            s2_wr_d      = 1'b1;
          end else begin
            s2_out_idx_d = '0;
            s2_status_d  = ST_NO_INDEX;
          end
        end
        OP_DESTROY: begin
          if (!known) begin
            s2_status_d = ST_UNALLOCATED;
          end else if (ring_full) begin
            s2_status_d = ST_OVERFLOW;
            s2_gsel_d   = GS_STORED;
          end else begin
            fq_we     = 1'b1;
            tail_d    = (tail_q == IdxW'(MAX_HANDLES - 1)) ? '0 : tail_q + IdxW'(1);
            count_d   = count_q + CntW'(1);
            s2_gsel_d = GS_BUMP;
            s2_wr_d   = 1'b1;
          end
        end
        OP_QUERY: begin
          if (!known) begin
            s2_status_d = ST_UNALLOCATED;
          end else begin
            s2_gsel_d = GS_STORED;
            s2_chk_d  = 1'b1;
          end
        end
        default: begin
          // unused opcode: echo only
          s2_status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      fresh_q    <= '0;
    end else begin
      s1_valid_q <= req_fire;
      s2_valid_q <= s1_valid_q;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      fresh_q    <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_op_q  <= req_i.op;
      s1_idx_q <= req_i.index;
      s1_gen_q <= req_i.generation;
    end
    s2_addr_q    <= s2_addr_d;
    s2_out_idx_q <= s2_out_idx_d;
    s2_status_q  <= s2_status_d;
    s2_gsel_q    <= s2_gsel_d;
    s2_wr_q      <= s2_wr_d;
    s2_chk_q     <= s2_chk_d;
    s2_qgen_q    <= s1_gen_q;
  end

  // free ring: head entry is kept prefetched, bypassing a same-cycle push
  always_ff @(posedge clk_i) begin
    if (fq_we) begin
      fq_mem[tail_q] <= fq_wdata;
    end
    fq_head_q <= (fq_we && (tail_q == head_d)) ? fq_wdata : fq_mem[head_d];
  end

  // ---------------------------------------------------------------------------
  // Table stage: read-modify-write of the generation table
  // ---------------------------------------------------------------------------
  assign gt_we    = s2_valid_q && s2_wr_q;
  assign gt_wdata = (s2_gsel_q == GS_BUMP) ? gt_rd_q + GEN_BITS'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (gt_we) begin
      gt_mem[s2_addr_q] <= gt_wdata;
    end
    gt_rd_q <= (gt_we && (s2_addr_q == s2_addr_d)) ? gt_wdata : gt_mem[s2_addr_d];
  end

  always_comb begin
    case (s2_gsel_q)
      GS_STORED: gen_val = gt_rd_q;
      GS_BUMP:   gen_val = gt_wdata;
      default:   gen_val = '0;
    endcase
    rsp_d.out_index      = s2_out_idx_q;
    rsp_d.out_generation = GenOutW'(gen_val);
    rsp_d.alive          = s2_chk_q && (gt_rd_q == GEN_BITS'(s2_qgen_q));
    rsp_d.status         = s2_status_q;
  end

  gha_out_fifo #(
    .Depth (OutFifoDepth)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (rsp_d),
    .pop_i       (rsp_o.ready),
    .valid_o     (fifo_valid),
    .data_o      (fifo_data),
    .count_o     (fifo_cnt)
  );

  assign rsp_o.valid          = fifo_valid;
  assign rsp_o.out_index      = fifo_data.out_index;
  assign rsp_o.out_generation = fifo_data.out_generation;
  assign rsp_o.alive          = fifo_data.alive;
  assign rsp_o.status         = fifo_data.status;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_HANDLES))
    else $error("free count exceeds handle count");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= CntW'(MAX_HANDLES))
    else $error("fresh index beyond handle count");

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= OccW'(OutFifoDepth))
    else $error("more results in flight than queue slots");

  a_pipe_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> s1_valid_q ##1 s2_valid_q)
    else $error("request lost between stages");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_pop |-> (count_q != '0) && !fq_we)
    else $error("free ring popped while empty");

endmodule

### sv/gha_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Small circular queue that holds finished results until the receiver
// takes them. The producer keeps its own credit count and never overfills.
// ----------------------------------------------------------------------------
module gha_out_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  gha_pkg::rsp_t                 push_data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output gha_pkg::rsp_t                 data_o,
  output logic [$clog2(Depth+1)-1:0]    count_o
);
  import gha_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rsp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(Depth)) && push_i |-> do_pop)
    else $error("result queue written while full");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with misaligned pointers");

endmodule
